@@ design/hrecg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrecg_pkg
// Types, constants and helpers for the heart rate packet parser and ECG
// synthesizer.
// ----------------------------------------------------------------------------
package hrecg_pkg;

  localparam int MAX_INTERVALS = 10;
  localparam int CNT_W         = 4;
  localparam int LEN_W         = 11;
  localparam int RATE_W        = 11;
  localparam int PROD_W        = 27;

  localparam logic [LEN_W-1:0]  BUFFER_DEPTH   = 11'd1024;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 11'd150;
  localparam logic [LEN_W-1:0]  TEMPLATE_LEN   = 11'd96;

  localparam logic [7:0] FLAG_RATE16    = 8'h01;
  localparam logic [7:0] FLAG_ENERGY    = 8'h08;
  localparam logic [7:0] FLAG_INTERVALS = 8'h10;

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_RATE_LO,
    PH_RATE_HI,
    PH_EN_LO,
    PH_EN_HI,
    PH_INTERVALS
  } phase_e;

  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_SAMPLE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic       op;
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       heart_rate;
    logic [15:0]       energy;
    logic [3:0]        interval_count;
    logic [10:0]       sample_total;
    logic [7:0]        missed_packets;
    logic signed [7:0] sample;
    logic              sample_valid;
    logic              last_sample;
  } out_item_t;

  localparam logic signed [7:0] BEAT_SHAPE [96] = '{
    8'sd0, 8'sd0, 8'sd1, 8'sd1, 8'sd2, 8'sd3, 8'sd2, 8'sd2, 8'sd3, 8'sd4, 8'sd5, 8'sd4,
    8'sd1, -8'sd1, -8'sd2, -8'sd2, -8'sd2, -8'sd1, -8'sd2, -8'sd3, -8'sd4, -8'sd2,
    8'sd0, -8'sd1, -8'sd6, -8'sd6, 8'sd13, 8'sd55, 8'sd99, 8'sd114, 8'sd90, 8'sd39,
    -8'sd5, -8'sd21, -8'sd14, -8'sd2, 8'sd3, 8'sd2, 8'sd0, 8'sd0, 8'sd0, 8'sd0,
    8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd3, 8'sd4, 8'sd4, 8'sd5, 8'sd6, 8'sd7, 8'sd9,
    8'sd10, 8'sd11, 8'sd12, 8'sd14, 8'sd15, 8'sd17, 8'sd19, 8'sd21, 8'sd24, 8'sd27,
    8'sd29, 8'sd32, 8'sd35, 8'sd38, 8'sd41, 8'sd44, 8'sd46, 8'sd49, 8'sd51, 8'sd50,
    8'sd47, 8'sd42, 8'sd35, 8'sd27, 8'sd19, 8'sd12, 8'sd5, 8'sd4, 8'sd3, 8'sd2, 8'sd0,
    -8'sd2, -8'sd3, -8'sd5, -8'sd5, -8'sd5, -8'sd4, -8'sd3, -8'sd2, -8'sd2, -8'sd1,
    -8'sd1, 8'sd0
  };

  // Segment length of one interval, saturated at the buffer depth.
  function automatic logic [LEN_W-1:0] seg_from_prod(input logic [PROD_W-1:0] prod);
    logic [PROD_W-11:0] seg;
    begin
      seg = prod[PROD_W-1:10];
      if (seg > (PROD_W-10)'(BUFFER_DEPTH)) begin
        seg_from_prod = BUFFER_DEPTH;
      end else begin
        seg_from_prod = seg[LEN_W-1:0];
      end
    end
  endfunction

  // Add two sample counts, saturating at the buffer depth.
  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s > {1'b0, BUFFER_DEPTH}) begin
        sat_add = BUFFER_DEPTH;
      end else begin
        sat_add = s[LEN_W-1:0];
      end
    end
  endfunction

  function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    min_len = (a < b) ? a : b;
  endfunction

endpackage

@@ design/heart_rate_packet_to_ecg_synth_core.sv @@
`timescale 1ns / 1ps
// An accepted transaction's result is registered in the output or the skid register.
// Throughput: one transaction per cycle unless a rate sweep or a full skid register stalls
// input; a two-entry output stage absorbs one stall. A write of sample_rate recomputes the stored
// segment lengths one interval per cycle through the shared multiplier, holding off input.
// Reset: asynchronous, active low; parser idle, nothing to play, sample_rate = 150.
// ----------------------------------------------------------------------------
// heart_rate_packet_to_ecg_synth_core
// Parses heart rate measurement packets byte by byte, reports a summary per
// packet and plays a synthetic ECG stream sized from the RR intervals.
// ----------------------------------------------------------------------------
module heart_rate_packet_to_ecg_synth_core #(
  parameter int MaxIntervals = hrecg_pkg::MAX_INTERVALS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  hrecg_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hrecg_pkg::out_item_t                out_item_o,
  input  logic                                cfg_we_i,
  input  logic [hrecg_pkg::RATE_W-1:0]        cfg_data_i
);

  localparam int IdxW  = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int CntW  = hrecg_pkg::CNT_W;
  localparam int LenW  = hrecg_pkg::LEN_W;
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MaxIntervals);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxIntervals - 1);

  // Parser state
  hrecg_pkg::phase_e   phase_q, phase_d;
  logic [7:0]          flags_q, flags_d;
  logic [15:0]         rate_q, rate_d;
  logic [15:0]         energy_q, energy_d;
  logic [7:0]          hold_q, hold_d;
  logic                pend_q, pend_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [7:0]          missed_q, missed_d;
  logic [LenW-1:0]     sum_q, sum_d;

  // Playback state
  logic [CntW-1:0]     pseg_q, pseg_d;
  logic [LenW-1:0]     poff_q, poff_d;
  logic [LenW-1:0]     slen_q, slen_d;
  logic [LenW-1:0]     left_q, left_d;

  // Configuration and recompute sweep
  logic [hrecg_pkg::RATE_W-1:0] srate_q, srate_d;
  logic                sweep_q, sweep_d;
  logic [IdxW-1:0]     sidx_q, sidx_d;

  // Interval store and per-interval segment lengths
  logic [15:0]         store_q [MaxIntervals];
  logic [LenW-1:0]     seg_q   [MaxIntervals];
  logic                store_wr;
  logic                seg_wr;
  logic [IdxW-1:0]     seg_widx;

  // Output stage
  hrecg_pkg::out_item_t out_q, skid_q, res;
  logic                out_valid_q, skid_valid_q;
  logic                res_valid;
  logic                in_fire, out_fire;

  // Shared multiplier
  logic [15:0]                   mult_a;
  logic [hrecg_pkg::PROD_W-1:0]  prod;
  logic [LenW-1:0]               seg_new;

  logic [CntW-1:0]     nxt_seg;
  logic [LenW-1:0]     sum_base;
  logic [LenW-1:0]     seg0;
  logic [CntW-1:0]     seg_cur;
  logic [LenW-1:0]     off_cur;
  logic [LenW-1:0]     len_cur;

  assign in_stall_o  = sweep_q | skid_valid_q;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_fire    = out_valid_q & ~out_stall_i;

  assign mult_a  = sweep_q ? store_q[sidx_q] : {in_item_i.packet_byte, hold_q};
  assign prod    = hrecg_pkg::PROD_W'(mult_a) * hrecg_pkg::PROD_W'(srate_q);
  assign seg_new = hrecg_pkg::seg_from_prod(prod);

  // Next segment with a nonzero length after the current one, else the fill count.
  always_comb begin
    nxt_seg = fill_q;
    for (int i = MaxIntervals - 1; i >= 0; i--) begin
      if ((CntW'(i) > pseg_q) && (CntW'(i) < fill_q) && (seg_q[i] != '0)) begin
        nxt_seg = CntW'(i);
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    rate_d   = rate_q;
    energy_d = energy_q;
    hold_d   = hold_q;
    pend_d   = pend_q;
    fill_d   = fill_q;
    missed_d = missed_q;
    sum_d    = sum_q;
    pseg_d   = pseg_q;
    poff_d   = poff_q;
    slen_d   = slen_q;
    left_d   = left_q;
    srate_d  = srate_q;
    sweep_d  = sweep_q;
    sidx_d   = sidx_q;
    store_wr = 1'b0;
    seg_wr   = 1'b0;
    seg_widx = fill_q[IdxW-1:0];
    res       = '0;
    res_valid = 1'b0;
    sum_base = '0;
    seg0     = '0;
    seg_cur  = pseg_q;
    off_cur  = poff_q;
    len_cur  = slen_q;

    // Recompute one segment length per cycle after a rate change
    if (sweep_q) begin
      seg_wr   = 1'b1;
      seg_widx = sidx_q;
      sum_base = (sidx_q == '0) ? '0 : sum_q;
      sum_d    = (CntW'(sidx_q) < fill_q) ? hrecg_pkg::sat_add(sum_base, seg_new) : sum_base;
      sweep_d  = (sidx_q != LastIdx);
      sidx_d   = sidx_q + 1'b1;
    end

    if (cfg_we_i) begin
      srate_d = cfg_data_i;
      sweep_d = 1'b1;
      sidx_d  = '0;
    end

    if (in_fire) begin
      if (in_item_i.op == hrecg_pkg::OP_BYTE) begin
        case (phase_q)
          hrecg_pkg::PH_FLAGS: begin
            flags_d  = in_item_i.packet_byte;
            rate_d   = '0;
            energy_d = '0;
            fill_d   = '0;
            sum_d    = '0;
            pend_d   = 1'b0;
            hold_d   = '0;
            left_d   = '0;
            phase_d  = hrecg_pkg::PH_RATE_LO;
          end
          hrecg_pkg::PH_RATE_LO: begin
            rate_d = {8'h00, in_item_i.packet_byte};
            if ((flags_q & hrecg_pkg::FLAG_RATE16) != '0) begin
              phase_d = hrecg_pkg::PH_RATE_HI;
            end else if ((flags_q & hrecg_pkg::FLAG_ENERGY) != '0) begin
              phase_d = hrecg_pkg::PH_EN_LO;
            end else begin
              phase_d = hrecg_pkg::PH_INTERVALS;
            end
          end
          hrecg_pkg::PH_RATE_HI: begin
            rate_d = {in_item_i.packet_byte, rate_q[7:0]};
            if ((flags_q & hrecg_pkg::FLAG_ENERGY) != '0) begin
              phase_d = hrecg_pkg::PH_EN_LO;
            end else begin
              phase_d = hrecg_pkg::PH_INTERVALS;
            end
          end
          hrecg_pkg::PH_EN_LO: begin
            energy_d = {8'h00, in_item_i.packet_byte};
            phase_d  = hrecg_pkg::PH_EN_HI;
          end
          hrecg_pkg::PH_EN_HI: begin
            energy_d = {in_item_i.packet_byte, energy_q[7:0]};
            phase_d  = hrecg_pkg::PH_INTERVALS;
          end
          default: begin
            if ((flags_q & hrecg_pkg::FLAG_INTERVALS) != '0) begin
              if (!pend_q) begin
                hold_d = in_item_i.packet_byte;
                pend_d = 1'b1;
              end else begin
                pend_d = 1'b0;
                // drop intervals beyond the store
                if (fill_q < MaxCnt) begin
                  store_wr = 1'b1;
                  seg_wr   = 1'b1;
                  sum_d    = hrecg_pkg::sat_add(sum_q, seg_new);
                  fill_d   = fill_q + 1'b1;
                end
              end
            end
          end
        endcase

        if (in_item_i.last_byte) begin
          if ((flags_d & hrecg_pkg::FLAG_INTERVALS) != '0) begin
            missed_d = '0;
          end else begin
            missed_d = missed_q + 1'b1;
          end
          seg0    = (seg_wr && (fill_q == '0)) ? seg_new : seg_q[0];
          pseg_d  = '0;
          poff_d  = '0;
          slen_d  = (fill_d != '0) ? hrecg_pkg::min_len(seg0, sum_d) : '0;
          left_d  = sum_d;
          phase_d = hrecg_pkg::PH_FLAGS;
          pend_d  = 1'b0;

          res_valid          = 1'b1;
          res.kind           = hrecg_pkg::KIND_SUMMARY;
          res.heart_rate     = rate_d;
          res.energy         = energy_d;
          res.interval_count = fill_d;
          res.sample_total   = sum_d;
          res.missed_packets = missed_d;
        end
      end else begin
        res_valid = 1'b1;
        res.kind  = hrecg_pkg::KIND_SAMPLE;
        if (left_q != '0) begin
          // advance past finished and empty segments
          if ((poff_q >= slen_q) && (pseg_q < fill_q)) begin
            seg_cur = nxt_seg;
            off_cur = '0;
            len_cur = (nxt_seg < fill_q)
                    ? hrecg_pkg::min_len(seg_q[nxt_seg[IdxW-1:0]], left_q) : left_q;
          end
          if ((seg_cur < fill_q) && (off_cur < hrecg_pkg::TEMPLATE_LEN)) begin
            res.sample = hrecg_pkg::BEAT_SHAPE[off_cur[6:0]];
          end
          pseg_d           = seg_cur;
          poff_d           = off_cur + 1'b1;
          slen_d           = len_cur;
          left_d           = left_q - 1'b1;
          res.sample_valid = 1'b1;
          res.last_sample  = (left_q == LenW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hrecg_pkg::PH_FLAGS;
      flags_q  <= '0;
      rate_q   <= '0;
      energy_q <= '0;
      hold_q   <= '0;
      pend_q   <= 1'b0;
      fill_q   <= '0;
      missed_q <= '0;
      sum_q    <= '0;
      pseg_q   <= '0;
      poff_q   <= '0;
      slen_q   <= '0;
      left_q   <= '0;
      srate_q  <= hrecg_pkg::SAMPLE_RATE_RST;
      sweep_q  <= 1'b0;
      sidx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      rate_q   <= rate_d;
      energy_q <= energy_d;
      hold_q   <= hold_d;
      pend_q   <= pend_d;
      fill_q   <= fill_d;
      missed_q <= missed_d;
      sum_q    <= sum_d;
      pseg_q   <= pseg_d;
      poff_q   <= poff_d;
      slen_q   <= slen_d;
      left_q   <= left_d;
      srate_q  <= srate_d;
      sweep_q  <= sweep_d;
      sidx_q   <= sidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[fill_q[IdxW-1:0]] <= {in_item_i.packet_byte, hold_q};
    end
    if (seg_wr) begin
      seg_q[seg_widx] <= seg_new;
    end
  end

  // Two-entry output stage: a result parks in the skid register while the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

@@ tb/heart_rate_packet_to_ecg_synth_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_packet_to_ecg_synth_core_tb
// Self-checking bench: a queue-fed driver sends packet bytes and sample
// requests, a monitor predicts each summary and ECG sample at acceptance and
// compares every result field by field. Idle and stall rates change by phase,
// and sample_rate is rewritten between phases, once mid-playback.
// ----------------------------------------------------------------------------
module heart_rate_packet_to_ecg_synth_core_tb;
  import hrecg_pkg::*;

  localparam int  CLK_HALF_NS  = 4;
  localparam int  RESET_CYCLES = 9;
  localparam int  DRAIN_CYCLES = 16;
  localparam int  MAX_BAD_SHOWN = 10;
  localparam longint RUN_LIMIT_NS = 64'd4_000_000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i    = 1'b0;
  logic [RATE_W-1:0] cfg_data_i = '0;

  heart_rate_packet_to_ecg_synth_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Link traffic waiting to be sent and reports predicted but not yet seen.
  in_item_t  link_q[$];
  out_item_t report_q[$];
  int        n_pushed   = 0;
  int        n_accepted = 0;
  int        n_bad      = 0;
  bit        in_taken   = 1'b0;
  int        send_gap_pct = 7;
  int        rx_stall_pct = 62;
  int unsigned gen_rate = SAMPLE_RATE_RST;

  // Mirror of the parser and the playback position.
  int unsigned rate_now   = SAMPLE_RATE_RST;
  phase_e      parse_ph   = PH_FLAGS;
  logic [7:0]  flags_q    = '0;
  logic [15:0] hr_q       = '0;
  logic [15:0] energy_q   = '0;
  logic [7:0]  lo_hold    = '0;
  bit          lo_pend    = 1'b0;
  logic [15:0] rr_q [MAX_INTERVALS];
  int unsigned rr_n       = 0;
  logic [7:0]  missed_q   = '0;
  int unsigned seg_idx    = 0;
  int unsigned seg_off    = 0;
  int unsigned seg_len    = 0;
  int unsigned left_n     = 0;

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  function automatic int unsigned rr_samples(input logic [15:0] ival,
                                             input int unsigned rate);
    rr_samples = (32'(ival) * rate) >> 10;
  endfunction

  task automatic parse_and_play(input in_item_t it);
    out_item_t   want;
    int unsigned total;
    int unsigned n;
    int unsigned i;
    want = '0;
    if (it.op == OP_BYTE) begin
      case (parse_ph)
        PH_FLAGS: begin
          flags_q  = it.packet_byte;
          hr_q     = '0;
          energy_q = '0;
          rr_n     = 0;
          lo_pend  = 1'b0;
          lo_hold  = '0;
          left_n   = 0;
          parse_ph = PH_RATE_LO;
        end
        PH_RATE_LO: begin
          hr_q = {8'h00, it.packet_byte};
          if ((flags_q & FLAG_RATE16) != 0) parse_ph = PH_RATE_HI;
          else if ((flags_q & FLAG_ENERGY) != 0) parse_ph = PH_EN_LO;
          else parse_ph = PH_INTERVALS;
        end
        PH_RATE_HI: begin
          hr_q[15:8] = it.packet_byte;
          if ((flags_q & FLAG_ENERGY) != 0) parse_ph = PH_EN_LO;
          else parse_ph = PH_INTERVALS;
        end
        PH_EN_LO: begin
          energy_q = {8'h00, it.packet_byte};
          parse_ph = PH_EN_HI;
        end
        PH_EN_HI: begin
          energy_q[15:8] = it.packet_byte;
          parse_ph = PH_INTERVALS;
        end
        default: begin
          if ((flags_q & FLAG_INTERVALS) != 0) begin
            if (!lo_pend) begin
              lo_hold = it.packet_byte;
              lo_pend = 1'b1;
            end else begin
              lo_pend = 1'b0;
              // drop intervals beyond the store
              if (rr_n < MAX_INTERVALS) begin
                rr_q[rr_n] = {it.packet_byte, lo_hold};
                rr_n++;
              end
            end
          end
        end
      endcase
      if (!it.last_byte) return;

      if ((flags_q & FLAG_INTERVALS) != 0) missed_q = '0;
      else missed_q = missed_q + 8'd1;
      total = 0;
      for (i = 0; i < rr_n; i++) total += rr_samples(rr_q[i], rate_now);
      if (total > BUFFER_DEPTH) total = BUFFER_DEPTH;
      seg_idx = 0;
      seg_off = 0;
      if (rr_n > 0) begin
        n = rr_samples(rr_q[0], rate_now);
        seg_len = (n < total) ? n : total;
      end else begin
        seg_len = 0;
      end
      left_n = total;

      want.kind           = KIND_SUMMARY;
      want.heart_rate     = hr_q;
      want.energy         = energy_q;
      want.interval_count = 4'(rr_n);
      want.sample_total   = 11'(total);
      want.missed_packets = missed_q;
      parse_ph = PH_FLAGS;
      lo_pend  = 1'b0;
      report_q.push_back(want);
      return;
    end

    want.kind = KIND_SAMPLE;
    if (left_n != 0) begin
      // advance past finished segments; the rate in force now sizes the next one
      while (seg_off >= seg_len && seg_idx < rr_n) begin
        seg_idx++;
        seg_off = 0;
        if (seg_idx < rr_n) begin
          n = rr_samples(rr_q[seg_idx], rate_now);
          seg_len = (n < left_n) ? n : left_n;
        end else begin
          seg_len = left_n;
        end
      end
      if (seg_idx < rr_n && seg_off < TEMPLATE_LEN) want.sample = BEAT_SHAPE[seg_off];
      seg_off++;
      left_n--;
      want.sample_valid = 1'b1;
      want.last_sample  = (left_n == 0);
    end
    report_q.push_back(want);
  endtask

  function automatic string report_str(input out_item_t r);
    report_str = $sformatf("kind=%0d hr=%0d en=%0d cnt=%0d tot=%0d miss=%0d smp=%0d v=%0d last=%0d",
                           r.kind, r.heart_rate, r.energy, r.interval_count,
                           r.sample_total, r.missed_packets, r.sample,
                           r.sample_valid, r.last_sample);
  endfunction

  task automatic check_report(input out_item_t got);
    out_item_t want;
    string     bad;
    if (report_q.size() == 0) begin
      n_bad++;
      if (n_bad <= MAX_BAD_SHOWN)
        $display("%0t: unexpected result: %s", $time, report_str(got));
      return;
    end
    want = report_q.pop_front();
    bad = "";
    if (got.kind !== want.kind) bad = {bad, " kind"};
    if (got.heart_rate !== want.heart_rate) bad = {bad, " heart_rate"};
    if (got.energy !== want.energy) bad = {bad, " energy"};
    if (got.interval_count !== want.interval_count) bad = {bad, " interval_count"};
    if (got.sample_total !== want.sample_total) bad = {bad, " sample_total"};
    if (got.missed_packets !== want.missed_packets) bad = {bad, " missed_packets"};
    if (got.sample !== want.sample) bad = {bad, " sample"};
    if (got.sample_valid !== want.sample_valid) bad = {bad, " sample_valid"};
    if (got.last_sample !== want.last_sample) bad = {bad, " last_sample"};
    if (bad != "") begin
      n_bad++;
      if (n_bad <= MAX_BAD_SHOWN) begin
        $display("%0t: mismatch in%s", $time, bad);
        $display("  expected %s", report_str(want));
        $display("  actual   %s", report_str(got));
      end
    end
  endtask

  // Driver: present the next transaction once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (link_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_item_i  <= link_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) rate_now = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        parse_and_play(in_item_i);
        n_accepted++;
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) check_report(out_item_o);
    end
  end

  task automatic push_item(input logic op, input logic [7:0] b, input logic last);
    in_item_t it;
    it.op          = op;
    it.packet_byte = b;
    it.last_byte   = last;
    link_q.push_back(it);
    n_pushed++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    push_item(OP_BYTE, b, last);
  endtask

  // Byte and last fields are don't-care on requests; randomize them anyway.
  task automatic push_samples(input int n);
    int i;
    for (i = 0; i < n; i++) push_item(OP_SAMPLE, 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input int unsigned v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= RATE_W'(v);
    gen_rate = v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One packet with random content, then requests that play some, all or past the end of it.
  task automatic queue_packet();
    logic [7:0]  flg;
    logic [7:0]  pkt[$];
    logic [15:0] ival;
    int unsigned ival_cap;
    int unsigned total;
    int          k;
    int          kept;
    int          i;
    int          sel;
    int          n_send;
    int          plays;
    bit          cut;
    flg = 8'($urandom);
    if ($urandom_range(3) != 0) flg = flg | FLAG_INTERVALS;
    pkt.push_back(flg);
    pkt.push_back(8'($urandom));
    if ((flg & FLAG_RATE16) != 0) pkt.push_back(8'($urandom));
    if ((flg & FLAG_ENERGY) != 0) begin
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
    end
    total = 0;
    kept  = 0;
    if ((flg & FLAG_INTERVALS) != 0) begin
      sel = $urandom_range(9);
      if (sel < 2) k = 0;
      else if (sel < 8) k = $urandom_range(1, 3);
      else k = $urandom_range(4, MAX_INTERVALS + 3);
      // cap most intervals at about 130 samples at the current rate, a little longer than one beat
      ival_cap = (130 * 1024) / gen_rate;
      if (ival_cap > 16'hFFFF) ival_cap = 16'hFFFF;
      for (i = 0; i < k; i++) begin
        sel = $urandom_range(9);
        if (sel < 8) ival = 16'($urandom_range(0, ival_cap));
        else if (sel == 8) ival = 16'($urandom);
        else ival = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        pkt.push_back(ival[7:0]);
        pkt.push_back(ival[15:8]);
        if (kept < MAX_INTERVALS) begin
          total += rr_samples(ival, gen_rate);
          kept++;
        end
      end
    end else begin
      k = $urandom_range(0, 2);
      for (i = 0; i < k; i++) pkt.push_back(8'($urandom));
    end
    if ($urandom_range(9) == 0) pkt.push_back(8'($urandom));
    if (total > BUFFER_DEPTH) total = BUFFER_DEPTH;

    cut = ($urandom_range(9) == 0);
    n_send = cut ? $urandom_range(1, pkt.size()) : pkt.size();
    for (i = 0; i < n_send; i++) push_byte(pkt[i], i == n_send - 1);

    if (cut) plays = $urandom_range(0, 20);
    else if (total <= 250 && $urandom_range(3) != 0) plays = total + $urandom_range(0, 2);
    else plays = $urandom_range(0, (total < 60) ? total : 60);
    push_samples(plays);
  endtask

  task automatic queue_traffic(input int n_items);
    int start;
    int sel;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      sel = $urandom_range(99);
      if (sel < 8) push_byte(8'($urandom), 1'($urandom));
      else if (sel < 12) push_samples(1);
      else queue_packet();
    end
  endtask

  initial begin
    int p;
    int j;
    int n;
    logic [7:0] flg;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // request with nothing to play
    push_samples(1);
    // 8-bit rate, no intervals
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // 16-bit rate and energy at full scale, one interval, odd trailing byte
    push_byte(8'h19, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h55, 1'b1);
    push_samples(3);
    // new packet abandons the stream above; play it out and one past the end
    push_byte(8'h10, 1'b0);
    push_byte(8'h50, 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h18, 1'b0);
    push_byte(8'h00, 1'b1);
    push_samples(6);
    // short packet, then flags byte alone
    push_byte(8'h19, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hFF, 1'b1);
    // energy present, bytes after it ignored without the interval flag
    push_byte(8'h08, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hBB, 1'b1);
    // stream capped at the buffer depth; change the rate inside the first beat
    push_byte(8'h10, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h40, 1'b1);
    push_samples(2);
    write_rate(1);
    push_samples(20);

    write_rate(1023);
    queue_traffic(150);

    write_rate(1024);
    send_gap_pct = 62;
    rx_stall_pct = 7;
    queue_traffic(150);

    // run the missed-packet counter through its wrap with no idling
    write_rate(SAMPLE_RATE_RST);
    send_gap_pct = 0;
    rx_stall_pct = 0;
    for (p = 0; p < 258; p++) begin
      flg = 8'($urandom) & ~FLAG_INTERVALS;
      n = $urandom_range(1, 3);
      push_byte(flg, n == 1);
      for (j = 1; j < n; j++) push_byte(8'($urandom), j == n - 1);
      if ($urandom_range(9) == 0) push_samples(1);
    end

    write_rate($urandom_range(2, 1022));
    queue_traffic(60);

    wait_idle();
    if (report_q.size() != 0) $display("%0d predicted results never arrived", report_q.size());
    if (n_bad == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", report_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
